>>> rtl/brbq_pkg.sv
// Shared constants, types and codes for the byte ring buffer queue.
package brbq_pkg;

  localparam int DEPTH      = 4096;
  localparam int LANES      = 8;
  localparam int BYTE_W     = 8;
  localparam int CAP_W      = 12;
  localparam int LEN_W      = 4;
  localparam int SEQ_W      = $clog2(DEPTH);
  localparam int LANE_W     = $clog2(LANES);
  localparam int ROW_W      = SEQ_W - LANE_W;
  localparam int BANK_DEPTH = DEPTH / LANES;
  localparam int CNT_W      = $clog2(LANES + 1);
  localparam int CMD_W      = 2;

  // stream packing
  localparam int IN_USED_W   = 1 + LEN_W + LANES * BYTE_W;
  localparam int IN_DATA_W   = ((IN_USED_W + 7) / 8) * 8;
  localparam int OUT_USED_W  = 1 + CNT_W + CAP_W + LANES * BYTE_W;
  localparam int OUT_DATA_W  = ((OUT_USED_W + 7) / 8) * 8;
  localparam int IN_BYTE_LSB = 1 + LEN_W;

  // configuration port
  localparam int APB_W  = 32;
  localparam int ADDR_W = 3;
  localparam logic [ADDR_W-3:0] REG_CAPACITY = '0;
  localparam logic [CAP_W-1:0]  CAPACITY_RESET = CAP_W'(4095);

  typedef logic [SEQ_W-1:0]  seq_t;
  typedef logic [LANE_W-1:0] lane_t;
  typedef logic [ROW_W-1:0]  row_t;
  typedef logic [CNT_W-1:0]  cnt_t;
  typedef logic [BYTE_W-1:0] byte_t;
  typedef logic [CAP_W-1:0]  cap_t;

  typedef enum logic [CMD_W-1:0] {
    CMD_PUSH = 2'd0,
    CMD_POP  = 2'd1,
    CMD_PEEK = 2'd2
  } cmd_t;

  // request broadcast to every bank lane
  typedef struct packed {
    logic wr;
    seq_t base;
    cnt_t count;
  } lane_req_t;

endpackage

>>> rtl/brbq_ram.sv
// Generic single-write, single-read RAM with registered read data.
module brbq_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 512
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

>>> rtl/brbq_lane.sv
// One byte bank of the ring: picks its byte of the transfer and its row.
module brbq_lane (
  input  logic                clk,
  input  brbq_pkg::lane_t     lane_id,
  input  brbq_pkg::lane_req_t req,
  input  brbq_pkg::byte_t     wbytes [brbq_pkg::LANES],
  output brbq_pkg::byte_t     rbyte
);
  import brbq_pkg::*;

  lane_t pos;
  seq_t  seq;
  row_t  row;
  logic  active;

  // byte position within the transfer that lands in this bank
  always_comb begin
    pos    = lane_id - req.base[LANE_W-1:0];
    seq    = req.base + seq_t'(pos);
    row    = seq[SEQ_W-1:LANE_W];
    active = cnt_t'(pos) < req.count;
  end

  brbq_ram #(
    .WIDTH(BYTE_W),
    .DEPTH(BANK_DEPTH)
  ) u_ram (
    .clk  (clk),
    .we   (req.wr && active),
    .waddr(row),
    .wdata(wbytes[pos]),
    .raddr(row),
    .rdata(rbyte)
  );

endmodule

>>> rtl/brbq_merge.sv
// Rotate bank read data into transfer order and blank unused bytes.
module brbq_merge (
  input  brbq_pkg::byte_t bank_data [brbq_pkg::LANES],
  input  brbq_pkg::lane_t rot,
  input  brbq_pkg::cnt_t  count,
  input  logic            show,
  output brbq_pkg::byte_t out_bytes [brbq_pkg::LANES]
);
  import brbq_pkg::*;

  always_comb begin
    for (int j = 0; j < LANES; j++) begin
      if (show && (cnt_t'(j) < count)) begin
        out_bytes[j] = bank_data[lane_t'(rot + lane_t'(j))];
      end else begin
        out_bytes[j] = '0;
      end
    end
  end

endmodule

>>> rtl/byte_ring_buffer_queue.sv
// Top level of the byte ring buffer queue: control, bank lanes, merge and ports.
// Path: an accepted command is registered in the read stage (s1), then in the output slot (m_tvalid, m_tdata).
// Flow: no new command is taken while the previous one is in the bank read stage, which blocks.
// Reset (rst, synchronous): empty queue, capacity 4095, pipeline and output drained.
// Ring contents are not cleared; only bytes pushed since the last clear are ever returned.
module byte_ring_buffer_queue (
  input  logic                              clk,
  input  logic                              rst,
  // input stream
  input  logic                              s_tvalid,
  output logic                              s_tready,
  // s_tdata, lowest bit up: atomic, length, in_byte0 .. in_byte7, zero pad
  input  logic [brbq_pkg::IN_DATA_W-1:0]    s_tdata,
  // s_tuser: cmd
  input  logic [brbq_pkg::CMD_W-1:0]        s_tuser,
  // result stream
  output logic                              m_tvalid,
  input  logic                              m_tready,
  // m_tdata, lowest bit up: status, moved_count, fill_level, out_byte0 .. out_byte7, zero pad
  output logic [brbq_pkg::OUT_DATA_W-1:0]   m_tdata,
  // configuration port
  input  logic                              psel,
  input  logic                              penable,
  input  logic                              pwrite,
  input  logic [brbq_pkg::ADDR_W-1:0]       paddr,
  input  logic [brbq_pkg::APB_W-1:0]        pwdata,
  output logic [brbq_pkg::APB_W-1:0]        prdata,
  output logic                              pready
);
  import brbq_pkg::*;

  localparam int PAD_W = OUT_DATA_W - OUT_USED_W;

  // Bytes are addressed by their running stream index modulo DEPTH rather
  // than by ring position: the queue never holds DEPTH bytes, so no unread
  // byte is overwritten, and consecutive bytes always fall in distinct banks.
  cap_t  capacity;
  seq_t  wseq;
  seq_t  rseq;

  logic  s1_valid;
  logic  s1_status;
  cnt_t  s1_moved;
  cap_t  s1_fill;
  lane_t s1_rot;
  logic  s1_show;

  logic  s_xfer;
  logic  cfg_wr;

  cmd_t  in_cmd;
  logic  in_atomic;
  logic [LEN_W-1:0] in_len;
  byte_t in_bytes [LANES];

  cnt_t  len_sat;
  seq_t  held;
  seq_t  room;
  cnt_t  take;
  logic  status;
  logic  do_push;
  logic  do_pop;
  logic  show;
  seq_t  fill_after;

  lane_req_t req;
  byte_t bank_data [LANES];
  byte_t out_bytes [LANES];
  logic [LANES*BYTE_W-1:0] out_flat;

  assign pready   = 1'b1;
  assign cfg_wr   = psel && penable && pwrite && pready
                    && (paddr[ADDR_W-1:2] == REG_CAPACITY);
  assign prdata   = (paddr[ADDR_W-1:2] == REG_CAPACITY) ? APB_W'(capacity) : '0;

  // Accept only when the read stage is free and the output slot will be free.
  assign s_tready = !s1_valid && (!m_tvalid || m_tready);
  assign s_xfer   = s_tvalid && s_tready;

  // unpack the input transfer
  always_comb begin
    in_cmd    = cmd_t'(s_tuser);
    in_atomic = s_tdata[0];
    in_len    = s_tdata[LEN_W:1];
    for (int k = 0; k < LANES; k++) begin
      in_bytes[k] = s_tdata[IN_BYTE_LSB + k*BYTE_W +: BYTE_W];
    end
  end

  // command decode: clip the length, size the move, judge the outcome
  always_comb begin
    len_sat = (in_len > LEN_W'(LANES)) ? cnt_t'(LANES) : cnt_t'(in_len);
    held    = wseq - rseq;
    room    = seq_t'(capacity) - held;
    take    = '0;
    status  = 1'b0;
    do_push = 1'b0;
    do_pop  = 1'b0;
    show    = 1'b0;
    if (in_len == '0) begin
      status = 1'b1;
    end else begin
      case (in_cmd)
        CMD_PUSH: begin
          take = (seq_t'(len_sat) < room) ? len_sat : cnt_t'(room);
          if (in_atomic && (take < len_sat)) begin
            // reject the whole push on a shortfall
            status = 1'b1;
            take   = '0;
          end else begin
            do_push = 1'b1;
          end
        end
        CMD_POP, CMD_PEEK: begin
          take   = (seq_t'(len_sat) < held) ? len_sat : cnt_t'(held);
          show   = 1'b1;
          do_pop = (in_cmd == CMD_POP);
        end
        default: begin
          status = 1'b1;
        end
      endcase
    end
    if (do_push) begin
      fill_after = held + seq_t'(take);
    end else if (do_pop) begin
      fill_after = held - seq_t'(take);
    end else begin
      fill_after = held;
    end
    req.wr    = s_xfer && do_push;
    req.base  = (in_cmd == CMD_PUSH) ? wseq : rseq;
    req.count = take;
  end

  // control registers and read stage
  always_ff @(posedge clk) begin
    if (rst) begin
      capacity <= CAPACITY_RESET;
      wseq     <= '0;
      rseq     <= '0;
      s1_valid <= 1'b0;
      m_tvalid <= 1'b0;
    end else begin
      if (cfg_wr) begin
        // a new capacity empties the queue
        capacity <= pwdata[CAP_W-1:0];
        wseq     <= '0;
        rseq     <= '0;
      end else if (s_xfer) begin
        if (do_push) begin
          wseq <= wseq + seq_t'(take);
        end
        if (do_pop) begin
          rseq <= rseq + seq_t'(take);
        end
      end
      s1_valid <= s_xfer;
      // the output slot is always free when the read stage hands over
      if (s1_valid) begin
        m_tvalid <= 1'b1;
      end else if (m_tready) begin
        m_tvalid <= 1'b0;
      end
    end
  end

  // payload of the read stage and the output register
  always_ff @(posedge clk) begin
    if (s_xfer) begin
      s1_status <= status;
      s1_moved  <= take;
      s1_fill   <= cap_t'(fill_after);
      s1_rot    <= rseq[LANE_W-1:0];
      s1_show   <= show;
    end
    if (s1_valid) begin
      m_tdata <= {{PAD_W{1'b0}}, out_flat, s1_fill, s1_moved, s1_status};
    end
  end

  // one bank per byte lane
  for (genvar g = 0; g < LANES; g++) begin : g_lane
    brbq_lane u_lane (
      .clk    (clk),
      .lane_id(lane_t'(g)),
      .req    (req),
      .wbytes (in_bytes),
      .rbyte  (bank_data[g])
    );
  end

  brbq_merge u_merge (
    .bank_data(bank_data),
    .rot      (s1_rot),
    .count    (s1_moved),
    .show     (s1_show),
    .out_bytes(out_bytes)
  );

  always_comb begin
    for (int k = 0; k < LANES; k++) begin
      out_flat[k*BYTE_W +: BYTE_W] = out_bytes[k];
    end
  end

  // the read stage always lands in the output slot on the next edge
  a_s1_to_out: assert property (@(posedge clk) disable iff (rst)
    s1_valid |=> m_tvalid)
    else $error("read stage result not presented");

  // the output slot is empty while the read stage holds a command
  a_no_overlap: assert property (@(posedge clk) disable iff (rst)
    s1_valid |-> !m_tvalid)
    else $error("read stage and output slot both occupied");

  // an accepted command occupies the read stage next cycle
  a_accept_stage: assert property (@(posedge clk) disable iff (rst)
    s_tvalid && s_tready |=> s1_valid && !s_tready)
    else $error("accepted command missing from read stage");

  // the queue never holds more than the capacity
  a_fill_bound: assert property (@(posedge clk) disable iff (rst)
    (wseq - rseq) <= seq_t'(capacity))
    else $error("fill level above capacity");

endmodule
